@@ src/vscr_pkg.sv @@
// Shared types, codes and address helpers for the video scroll register and timing core.
package vscr_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_IDLE  = 2'd3;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam int NT_BYTES  = 2048;
  localparam int OAM_BYTES = 256;

  localparam logic [8:0] LAST_LINE  = 9'd261;
  localparam logic [8:0] LAST_DOT   = 9'd340;
  localparam logic [8:0] SKIP_DOT   = 9'd339;
  localparam logic [8:0] VBL_LINE   = 9'd241;
  localparam logic [8:0] VIS_LINES  = 9'd240;
  localparam logic [13:0] PAL_BASE  = 14'h3F00;
  localparam logic [13:0] NT_BASE   = 14'h2000;
  localparam logic [14:0] MASK_HORZ = 15'h041F;
  localparam logic [14:0] MASK_VERT = 15'h7BE0;
  localparam logic [5:0] PAL_RESET  = 6'h0F;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] chr_data;
    logic       sprite0_hit;
    logic       sprite_overflow;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_request;
    logic        nmi_level;
    logic        vblank_start;
    logic        chr_write;
    logic [12:0] chr_addr;
    logic [13:0] next_addr;
    logic [8:0]  scanline;
    logic [8:0]  dot;
    logic        line_render_strobe;
    logic        sprite_eval_strobe;
    logic        odd_field;
  } out_item_t;

  typedef struct packed {
    logic [8:0] dot;
    logic [8:0] line;
    logic       odd;
    logic       lstr;
    logic       sstr;
    logic       vbl_set;
    logic       vbl_clr;
    logic       inc_y;
    logic       copy_h;
    logic       copy_v;
  } tim_t;

  // Nametable index after mirroring.
  function automatic logic [10:0] nt_index(input logic [13:0] a, input logic vert);
    logic [10:0] r;
    if (vert) begin
      r = a[10:0];
    end else begin
      r = {a[11], a[9:0]};
    end
    return r;
  endfunction

  // Palette index; the backdrop entries of the sprite half alias the background half.
  function automatic logic [4:0] pal_index(input logic [13:0] a);
    logic [4:0] r;
    r = a[4:0];
    if (r[4] && r[1:0] == 2'b00) begin
      r[4] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [14:0] inc_fine_y(input logic [14:0] v);
    logic [14:0] r;
    logic [4:0]  y;
    r = v;
    y = v[9:5];
    if (v[14:12] != 3'd7) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (y == 5'd29) begin
        y = 5'd0;
        r[11] = ~v[11];
      end else if (y == 5'd31) begin
        y = 5'd0;
      end else begin
        y = y + 5'd1;
      end
      r[9:5] = y;
    end
    return r;
  endfunction

endpackage

@@ src/vscr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module vscr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/vscr_timing.sv @@
// Dot and scanline counter advance with the per-dot rendering events.
module vscr_timing (
  input  logic        tick_i,
  input  logic        rend_i,
  input  logic [8:0]  dot_i,
  input  logic [8:0]  line_i,
  input  logic        odd_i,
  output vscr_pkg::tim_t tim_o
);

  logic visible, pre, active, skip;

  always_comb begin
    visible = line_i < vscr_pkg::VIS_LINES;
    pre     = line_i == vscr_pkg::LAST_LINE;
    active  = tick_i && (visible || pre) && rend_i;
    skip    = tick_i && pre && dot_i == vscr_pkg::SKIP_DOT && rend_i && odd_i;

    tim_o.lstr    = active && visible && dot_i == 9'd255;
    tim_o.inc_y   = active && visible && dot_i == 9'd256;
    tim_o.copy_h  = active && dot_i == 9'd257;
    tim_o.sstr    = active && visible && dot_i == 9'd257;
    tim_o.vbl_clr = active && pre && dot_i == 9'd1;
    tim_o.copy_v  = active && pre && dot_i >= 9'd280 && dot_i <= 9'd304;
    tim_o.vbl_set = tick_i && line_i == vscr_pkg::VBL_LINE && dot_i == 9'd1;

    tim_o.dot  = dot_i;
    tim_o.line = line_i;
    tim_o.odd  = odd_i;
    if (skip) begin
      tim_o.dot  = 9'd0;
      tim_o.line = 9'd0;
      tim_o.odd  = ~odd_i;
    end else if (tick_i) begin
      if (dot_i >= vscr_pkg::LAST_DOT) begin
        tim_o.dot = 9'd0;
        if (line_i >= vscr_pkg::LAST_LINE) begin
          tim_o.line = 9'd0;
          tim_o.odd  = ~odd_i;
        end else begin
          tim_o.line = line_i + 9'd1;
        end
      end else begin
        tim_o.dot = dot_i + 9'd1;
      end
    end
  end

endmodule

@@ src/video_scroll_register_timing_core_top.sv @@
// Top level of the video scroll register and timing core.
//
//  Channel  | Direction | Handshake               | Payload
//  in       | input     | in_valid_i / in_stall_o | in_data_i  (vscr_pkg::in_item_t)
//  out      | output    | out_valid_o/ out_stall_i| out_data_o (vscr_pkg::out_item_t)
//  config   | input     | APB write/read          | mirroring mode when paddr[2] is 0
//
// Each transaction is registered on entry, processed combinationally and registered
// at the output, where its result is offered; one transaction can be taken every
// cycle while neither out_stall_i nor the nametable clear holds the input.
// After reset the nametable RAM is cleared one entry a cycle through every entry, during
// which in_stall_o stays high. While a result waits under out_stall_i, the input
// register holds one more transaction and in_stall_o rises once it is full.
module video_scroll_register_timing_core_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vscr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vscr_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NtAw  = $clog2(vscr_pkg::NT_BYTES);
  localparam int OamAw = $clog2(vscr_pkg::OAM_BYTES);

  logic                s1_valid_q;
  vscr_pkg::in_item_t  s1_item_q;
  logic                out_valid_q;
  vscr_pkg::out_item_t out_q, out_d;
  logic                advance, accept;

  logic        mirror_q;
  logic [7:0]  ctrl_q, ctrl_d, mask_q, mask_d, bus_q, bus_d, buf_q, buf_d;
  logic        buf_sel_q, buf_sel_d;
  logic [2:0]  stat_q, stat_d, fine_x_q, fine_x_d;
  logic [7:0]  spr_addr_q, spr_addr_d;
  logic [14:0] v_q, v_d, t_q, t_d;
  logic        w_q, w_d, prev_q, prev_d;
  logic [8:0]  dot_q, line_q;
  logic        odd_q;
  logic [5:0]  pal_q [32];
  logic        pal_we;
  logic [4:0]  pal_waddr;
  logic [vscr_pkg::OAM_BYTES-1:0] oam_vld_q;

  logic              clearing_q;
  logic [NtAw-1:0]   clr_cnt_q;

  logic              nt_we, nt_re, item_nt_we;
  logic [NtAw-1:0]   nt_waddr, nt_raddr, item_nt_addr;
  logic [7:0]        nt_wdata, nt_rdata;
  logic              oam_we;
  logic [7:0]        oam_rdata;

  vscr_pkg::tim_t    tim;
  logic              is_tick;
  logic [13:0]       addr;
  logic [14:0]       v_step;
  logic [7:0]        buf_eff;
  logic              nmi_upd, level, edge_det;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing_q || (s1_valid_q && !advance);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, mirror_q} : 32'd0;

  assign is_tick = advance && s1_item_q.operation == vscr_pkg::OP_TICK;

  vscr_timing u_timing (
    .tick_i (is_tick),
    .rend_i (mask_q[4] | mask_q[3]),
    .dot_i  (dot_q),
    .line_i (line_q),
    .odd_i  (odd_q),
    .tim_o  (tim)
  );

  assign nt_we    = clearing_q || item_nt_we;
  assign nt_waddr = clearing_q ? clr_cnt_q : item_nt_addr;
  assign nt_wdata = clearing_q ? 8'd0 : s1_item_q.write_data;

  vscr_ram #(.Width(8), .Depth(vscr_pkg::NT_BYTES)) u_nt_ram (
    .clk_i   (clk_i),
    .we_i    (nt_we),
    .waddr_i (nt_waddr),
    .wdata_i (nt_wdata),
    .re_i    (nt_re),
    .raddr_i (nt_raddr),
    .rdata_o (nt_rdata)
  );

  // The sprite RAM is read every cycle at the address the next transaction will use,
  // so its data is ready when that transaction is processed.
  vscr_ram #(.Width(8), .Depth(vscr_pkg::OAM_BYTES)) u_oam_ram (
    .clk_i   (clk_i),
    .we_i    (oam_we),
    .waddr_i (spr_addr_q[OamAw-1:0]),
    .wdata_i (s1_item_q.write_data),
    .re_i    (1'b1),
    .raddr_i (spr_addr_d[OamAw-1:0]),
    .rdata_o (oam_rdata)
  );

  always_comb begin
    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    bus_d      = bus_q;
    buf_d      = buf_q;
    buf_sel_d  = buf_sel_q;
    stat_d     = stat_q;
    fine_x_d   = fine_x_q;
    spr_addr_d = spr_addr_q;
    v_d        = v_q;
    t_d        = t_q;
    w_d        = w_q;
    prev_d     = prev_q;
    nmi_upd    = 1'b0;
    level      = 1'b0;
    edge_det   = 1'b0;
    item_nt_we = 1'b0;
    nt_re      = 1'b0;
    nt_raddr   = '0;
    oam_we     = 1'b0;
    pal_we     = 1'b0;
    addr       = v_q[13:0];
    item_nt_addr = vscr_pkg::nt_index(addr, mirror_q);
    pal_waddr  = vscr_pkg::pal_index(addr);
    v_step     = v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
    buf_eff    = buf_sel_q ? nt_rdata : buf_q;
    out_d      = '0;

    if (advance) begin
      case (s1_item_q.operation)
        vscr_pkg::OP_READ: begin
          case (s1_item_q.reg_index)
            vscr_pkg::REG_STATUS: begin
              out_d.read_data = {stat_q, bus_q[4:0]};
              stat_d[2] = 1'b0;
              w_d       = 1'b0;
              nmi_upd   = 1'b1;
            end
            vscr_pkg::REG_OAM_DATA: begin
              out_d.read_data = oam_vld_q[spr_addr_q[OamAw-1:0]] ? oam_rdata : 8'd0;
            end
            vscr_pkg::REG_DATA: begin
              nt_re = addr >= vscr_pkg::NT_BASE;
              if (addr >= vscr_pkg::PAL_BASE) begin
                out_d.read_data = {bus_q[7:6], pal_q[pal_waddr]};
                nt_raddr  = vscr_pkg::nt_index({2'b10, addr[11:0]}, mirror_q);
                buf_sel_d = 1'b1;
              end else begin
                out_d.read_data = buf_eff;
                nt_raddr = item_nt_addr;
                if (addr < vscr_pkg::NT_BASE) begin
                  buf_d     = s1_item_q.chr_data;
                  buf_sel_d = 1'b0;
                end else begin
                  buf_sel_d = 1'b1;
                end
              end
              v_d = v_step;
            end
            default: out_d.read_data = bus_q;
          endcase
        end
        vscr_pkg::OP_WRITE: begin
          bus_d = s1_item_q.write_data;
          case (s1_item_q.reg_index)
            vscr_pkg::REG_CTRL: begin
              ctrl_d       = s1_item_q.write_data;
              t_d[11:10]   = s1_item_q.write_data[1:0];
              nmi_upd      = 1'b1;
            end
            vscr_pkg::REG_MASK: mask_d = s1_item_q.write_data;
            vscr_pkg::REG_SPR_ADDR: spr_addr_d = s1_item_q.write_data;
            vscr_pkg::REG_OAM_DATA: begin
              oam_we     = 1'b1;
              spr_addr_d = spr_addr_q + 8'd1;
            end
            vscr_pkg::REG_SCROLL: begin
              if (!w_q) begin
                fine_x_d = s1_item_q.write_data[2:0];
                t_d[4:0] = s1_item_q.write_data[7:3];
              end else begin
                t_d[14:12] = s1_item_q.write_data[2:0];
                t_d[9:5]   = s1_item_q.write_data[7:3];
              end
              w_d = ~w_q;
            end
            vscr_pkg::REG_ADDR: begin
              if (!w_q) begin
                t_d[14]   = 1'b0;
                t_d[13:8] = s1_item_q.write_data[5:0];
              end else begin
                t_d[7:0] = s1_item_q.write_data;
                v_d      = t_d;
              end
              w_d = ~w_q;
            end
            vscr_pkg::REG_DATA: begin
              if (addr < vscr_pkg::NT_BASE) begin
                out_d.chr_write = 1'b1;
                out_d.chr_addr  = addr[12:0];
              end else if (addr < vscr_pkg::PAL_BASE) begin
                item_nt_we = 1'b1;
              end else begin
                pal_we = 1'b1;
              end
              v_d = v_step;
            end
            default: ;
          endcase
        end
        vscr_pkg::OP_TICK: begin
          if (tim.vbl_clr) begin
            stat_d = 3'd0;
          end
          if (tim.sstr) begin
            stat_d[0] = s1_item_q.sprite_overflow;
          end
          if (s1_item_q.sprite0_hit) begin
            stat_d[1] = 1'b1;
          end
          if (tim.vbl_set) begin
            stat_d[2] = 1'b1;
          end
          nmi_upd = tim.vbl_clr | tim.vbl_set;
          if (tim.inc_y) begin
            v_d = vscr_pkg::inc_fine_y(v_q);
          end
          if (tim.copy_h) begin
            v_d = (v_q & ~vscr_pkg::MASK_HORZ) | (t_q & vscr_pkg::MASK_HORZ);
          end
          if (tim.copy_v) begin
            v_d = (v_q & ~vscr_pkg::MASK_VERT) | (t_q & vscr_pkg::MASK_VERT);
          end
          out_d.vblank_start       = tim.vbl_set;
          out_d.line_render_strobe = tim.lstr;
          out_d.sprite_eval_strobe = tim.sstr;
        end
        default: ;
      endcase

      if (nmi_upd) begin
        level    = stat_d[2] & ctrl_d[7];
        edge_det = level & ~prev_q;
        prev_d   = level;
      end
      out_d.nmi_request = edge_det;
      out_d.nmi_level   = prev_d;
      out_d.next_addr   = v_d[13:0];
      out_d.scanline    = tim.line;
      out_d.dot         = tim.dot;
      out_d.odd_field   = tim.odd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mirror_q    <= 1'b0;
      ctrl_q      <= '0;
      mask_q      <= '0;
      bus_q       <= '0;
      buf_q       <= '0;
      buf_sel_q   <= 1'b0;
      stat_q      <= '0;
      fine_x_q    <= '0;
      spr_addr_q  <= '0;
      v_q         <= '0;
      t_q         <= '0;
      w_q         <= 1'b0;
      prev_q      <= 1'b0;
      dot_q       <= '0;
      line_q      <= vscr_pkg::LAST_LINE;
      odd_q       <= 1'b0;
      oam_vld_q   <= '0;
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      for (int i = 0; i < 32; i++) begin
        pal_q[i] <= vscr_pkg::PAL_RESET;
      end
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
        mirror_q <= pwdata[0];
      end
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == NtAw'(vscr_pkg::NT_BYTES - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        ctrl_q     <= ctrl_d;
        mask_q     <= mask_d;
        bus_q      <= bus_d;
        buf_q      <= buf_d;
        buf_sel_q  <= buf_sel_d;
        stat_q     <= stat_d;
        fine_x_q   <= fine_x_d;
        spr_addr_q <= spr_addr_d;
        v_q        <= v_d;
        t_q        <= t_d;
        w_q        <= w_d;
        prev_q     <= prev_d;
        dot_q      <= tim.dot;
        line_q     <= tim.line;
        odd_q      <= tim.odd;
      end
      if (oam_we) begin
        oam_vld_q[spr_addr_q[OamAw-1:0]] <= 1'b1;
      end
      if (pal_we) begin
        pal_q[pal_waddr] <= s1_item_q.write_data[5:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

@@ sim/video_scroll_register_timing_core_top_tb.sv @@
// Testbench for the video scroll register and timing core: predicted results checked per field.
`timescale 1ns / 1ps

class scroll_scoreboard;
  vscr_pkg::out_item_t pending_q[$];
  int unsigned         err_count;

  // Predictor state.
  bit        mirror_vert;
  bit [7:0]  ctrl_r, mask_r, spr_addr, bus_r, rbuf;
  bit [2:0]  stat_r;
  bit [7:0]  oam[256];
  bit [7:0]  nt[2048];
  bit [5:0]  pal[32];
  bit [14:0] v_r, t_r;
  bit [2:0]  fx_r;
  bit        w_r, nmi_prev, edge_r, odd_r;
  bit [8:0]  dot_r, line_r;

  function new();
    ctrl_r = 0; mask_r = 0; spr_addr = 0; bus_r = 0; rbuf = 0; stat_r = 0;
    foreach (oam[i]) oam[i] = 0;
    foreach (nt[i]) nt[i] = 0;
    foreach (pal[i]) pal[i] = vscr_pkg::PAL_RESET;
    v_r = 0; t_r = 0; fx_r = 0; w_r = 0; nmi_prev = 0; odd_r = 0;
    dot_r = 0; line_r = vscr_pkg::LAST_LINE; mirror_vert = 0; err_count = 0;
  endfunction

  function bit [10:0] nt_map(bit [13:0] a);
    if (mirror_vert) return a[10:0];
    return {a[11], a[9:0]};
  endfunction

  function bit [4:0] pal_map(bit [13:0] a);
    bit [4:0] r;
    r = a[4:0];
    if (r[4] && r[1:0] == 2'b00) r[4] = 1'b0;
    return r;
  endfunction

  function void nmi_eval();
    bit lvl;
    lvl = stat_r[2] & ctrl_r[7];
    if (lvl && !nmi_prev) edge_r = 1;
    nmi_prev = lvl;
  endfunction

  function void advance_v();
    v_r = v_r + (ctrl_r[2] ? 15'd32 : 15'd1);
  endfunction

  function void fine_y_step();
    bit [4:0] y;
    if (v_r[14:12] != 3'd7) v_r[14:12] = v_r[14:12] + 3'd1;
    else begin
      v_r[14:12] = 0;
      y = v_r[9:5];
      if (y == 29) begin
        y = 0; v_r[11] = ~v_r[11];
      end else if (y == 31) y = 0;
      else y = y + 1;
      v_r[9:5] = y;
    end
  endfunction

  function void note_input(vscr_pkg::in_item_t it);
    vscr_pkg::out_item_t o;
    bit [13:0] a;
    bit rend, vis, skip;
    o = '0;
    edge_r = 0;
    a = v_r[13:0];
    if (it.operation == vscr_pkg::OP_READ) begin
      case (it.reg_index)
        vscr_pkg::REG_STATUS: begin
          o.read_data = {stat_r, bus_r[4:0]};
          stat_r[2] = 0; w_r = 0; nmi_eval();
        end
        vscr_pkg::REG_OAM_DATA: o.read_data = oam[spr_addr];
        vscr_pkg::REG_DATA: begin
          if (a >= vscr_pkg::PAL_BASE) begin
            o.read_data = {bus_r[7:6], pal[pal_map(a)]};
            rbuf = nt[nt_map(a & 14'h2FFF)];
          end else begin
            o.read_data = rbuf;
            rbuf = (a < vscr_pkg::NT_BASE) ? it.chr_data : nt[nt_map(a)];
          end
          advance_v();
        end
        default: o.read_data = bus_r;
      endcase
    end else if (it.operation == vscr_pkg::OP_WRITE) begin
      bus_r = it.write_data;
      case (it.reg_index)
        vscr_pkg::REG_CTRL: begin
          ctrl_r = it.write_data; t_r[11:10] = it.write_data[1:0]; nmi_eval();
        end
        vscr_pkg::REG_MASK: mask_r = it.write_data;
        vscr_pkg::REG_SPR_ADDR: spr_addr = it.write_data;
        vscr_pkg::REG_OAM_DATA: begin
          oam[spr_addr] = it.write_data; spr_addr++;
        end
        vscr_pkg::REG_SCROLL: begin
          if (!w_r) begin
            fx_r = it.write_data[2:0]; t_r[4:0] = it.write_data[7:3];
          end else begin
            t_r[14:12] = it.write_data[2:0]; t_r[9:5] = it.write_data[7:3];
          end
          w_r = ~w_r;
        end
        vscr_pkg::REG_ADDR: begin
          if (!w_r) begin
            t_r[14] = 0; t_r[13:8] = it.write_data[5:0];
          end else begin
            t_r[7:0] = it.write_data; v_r = t_r;
          end
          w_r = ~w_r;
        end
        vscr_pkg::REG_DATA: begin
          if (a < vscr_pkg::NT_BASE) begin
            o.chr_write = 1; o.chr_addr = a[12:0];
          end else if (a < vscr_pkg::PAL_BASE) nt[nt_map(a)] = it.write_data;
          else pal[pal_map(a)] = it.write_data[5:0];
          advance_v();
        end
        default: ;
      endcase
    end else if (it.operation == vscr_pkg::OP_TICK) begin
      rend = mask_r[4] | mask_r[3];
      vis = line_r < vscr_pkg::VIS_LINES;
      skip = 0;
      if ((vis || line_r == vscr_pkg::LAST_LINE) && rend) begin
        if (line_r == vscr_pkg::LAST_LINE && dot_r == 1) begin
          stat_r = 0; nmi_eval();
        end
        if (dot_r == 255 && vis) o.line_render_strobe = 1;
        if (dot_r == 256 && vis) fine_y_step();
        if (dot_r == 257) begin
          v_r = (v_r & ~vscr_pkg::MASK_HORZ) | (t_r & vscr_pkg::MASK_HORZ);
          if (vis) begin
            o.sprite_eval_strobe = 1; stat_r[0] = it.sprite_overflow;
          end
        end
        if (line_r == vscr_pkg::LAST_LINE && dot_r >= 280 && dot_r <= 304)
          v_r = (v_r & ~vscr_pkg::MASK_VERT) | (t_r & vscr_pkg::MASK_VERT);
      end
      if (it.sprite0_hit) stat_r[1] = 1;
      if (line_r == vscr_pkg::VBL_LINE && dot_r == 1) begin
        stat_r[2] = 1; o.vblank_start = 1; nmi_eval();
      end
      if (line_r == vscr_pkg::LAST_LINE && dot_r == vscr_pkg::SKIP_DOT && rend && odd_r) begin
        dot_r = 0; line_r = 0; odd_r = ~odd_r; skip = 1;
      end
      if (!skip) begin
        if (dot_r == vscr_pkg::LAST_DOT) begin
          dot_r = 0;
          if (line_r == vscr_pkg::LAST_LINE) begin
            line_r = 0; odd_r = ~odd_r;
          end else line_r++;
        end else dot_r++;
      end
    end
    o.nmi_request = edge_r;
    o.nmi_level = nmi_prev;
    o.next_addr = v_r[13:0];
    o.scanline = line_r;
    o.dot = dot_r;
    o.odd_field = odd_r;
    pending_q.push_back(o);
  endfunction

  task report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  task check_result(vscr_pkg::out_item_t got);
    vscr_pkg::out_item_t e;
    if (pending_q.size() == 0) begin
      report("unexpected transaction", 0, 0);
      return;
    end
    e = pending_q.pop_front();
    if (got.read_data != e.read_data) report("read_data", got.read_data, e.read_data);
    if (got.nmi_request != e.nmi_request) report("nmi_request", got.nmi_request, e.nmi_request);
    if (got.nmi_level != e.nmi_level) report("nmi_level", got.nmi_level, e.nmi_level);
    if (got.vblank_start != e.vblank_start)
      report("vblank_start", got.vblank_start, e.vblank_start);
    if (got.chr_write != e.chr_write) report("chr_write", got.chr_write, e.chr_write);
    if (got.chr_addr != e.chr_addr) report("chr_addr", got.chr_addr, e.chr_addr);
    if (got.next_addr != e.next_addr) report("next_addr", got.next_addr, e.next_addr);
    if (got.scanline != e.scanline) report("scanline", got.scanline, e.scanline);
    if (got.dot != e.dot) report("dot", got.dot, e.dot);
    if (got.line_render_strobe != e.line_render_strobe)
      report("line_render_strobe", got.line_render_strobe, e.line_render_strobe);
    if (got.sprite_eval_strobe != e.sprite_eval_strobe)
      report("sprite_eval_strobe", got.sprite_eval_strobe, e.sprite_eval_strobe);
    if (got.odd_field != e.odd_field) report("odd_field", got.odd_field, e.odd_field);
  endtask
endclass

module video_scroll_register_timing_core_top_tb;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  vscr_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  vscr_pkg::out_item_t out_data_o;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned gap_pct = 0, stall_pct = 0;
  scroll_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  video_scroll_register_timing_core_top u_dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_mirroring(bit vert);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= {31'd0, vert};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.mirror_vert = vert;
  endtask

  // Presents one transaction and holds it until the block takes it; valid stays
  // high afterwards so the next transaction can follow without a gap.
  task automatic send_item(vscr_pkg::in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic send_op(logic [1:0] op, logic [2:0] r, logic [7:0] d);
    vscr_pkg::in_item_t it;
    it = '{operation: op, reg_index: r, write_data: d, chr_data: 8'($urandom_range(255)),
           sprite0_hit: 1'b0, sprite_overflow: 1'($urandom_range(1))};
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random mix: mostly ticks to move through frames, with register traffic.
  task automatic random_burst(int n);
    vscr_pkg::in_item_t it;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      it.chr_data = 8'($urandom_range(255));
      it.sprite0_hit = ($urandom_range(19) == 0);
      it.sprite_overflow = 1'($urandom_range(1));
      it.write_data = 8'($urandom_range(255));
      it.reg_index = 3'($urandom_range(7));
      if (k < 55) it.operation = vscr_pkg::OP_TICK;
      else if (k < 75) it.operation = vscr_pkg::OP_READ;
      else if (k < 97) it.operation = vscr_pkg::OP_WRITE;
      else it.operation = vscr_pkg::OP_IDLE;
      // Turn rendering on often so the per-dot events fire.
      if (it.operation == vscr_pkg::OP_WRITE && it.reg_index == vscr_pkg::REG_MASK &&
          $urandom_range(1))
        it.write_data[4:3] = 2'b11;
      send_item(it);
    end
  endtask

  // Runs ticks quickly up to a frame point of interest.
  task automatic ticks(int n);
    for (int i = 0; i < n; i++) send_op(vscr_pkg::OP_TICK, 3'd0, 8'd0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    write_mirroring(1'b0);
    // Directed: scroll, address, data port to every space, OAM, status.
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_CTRL, 8'h80);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_MASK, 8'h18);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_SCROLL, 8'hFF);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_SCROLL, 8'h00);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_ADDR, 8'h3F);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_ADDR, 8'h10);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_DATA, 8'hFF);
    send_op(vscr_pkg::OP_READ, vscr_pkg::REG_DATA, 8'h00);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_ADDR, 8'h24);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_ADDR, 8'h00);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_DATA, 8'hA5);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_ADDR, 8'h00);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_ADDR, 8'h00);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_DATA, 8'h5A);
    send_op(vscr_pkg::OP_READ, vscr_pkg::REG_DATA, 8'h00);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_SPR_ADDR, 8'hFF);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_OAM_DATA, 8'h33);
    send_op(vscr_pkg::OP_READ, vscr_pkg::REG_OAM_DATA, 8'h00);
    for (int r = 0; r < 8; r++) send_op(vscr_pkg::OP_READ, r[2:0], 8'h00);
    send_op(vscr_pkg::OP_IDLE, vscr_pkg::REG_DATA, 8'hFF);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_STATUS, 8'hE7);
    drain();
    write_mirroring(1'b1);
    // The pre-render line with rendering on: status clear, copies, then line wrap.
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_MASK, 8'h08);
    ticks(285);
    send_op(vscr_pkg::OP_READ, vscr_pkg::REG_STATUS, 8'h00);
    send_op(vscr_pkg::OP_WRITE, vscr_pkg::REG_CTRL, 8'h84);
    ticks(60);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 62) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 62) : 0;
      write_mirroring(ph[0]);
      random_burst(18);
      drain();
    end
    gap_pct = 0; stall_pct = 0;
    if (sb.err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

@@ files.f @@
src/vscr_pkg.sv
src/vscr_ram.sv
src/vscr_timing.sv
src/video_scroll_register_timing_core_top.sv
sim/video_scroll_register_timing_core_top_tb.sv
